// ===== hw/rtl/nbcw_pkg.sv =====
// Package for the nibble blitter colour-table writer.
// Holds codes, channel payload types and the front-to-back queue entry.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package nbcw_pkg;

	localparam int NBCW_ROM_BYTES   = 1048576;
	localparam int NBCW_BANK_BYTES  = 131072;
	localparam int NBCW_QUEUE_DEPTH = 4;

	typedef enum logic [1:0] {
		CMD_REG  = 2'd0,
		CMD_CLUT = 2'd1,
		CMD_GFX  = 2'd2,
		CMD_NOP  = 2'd3
	} nbcw_cmd_t;

	localparam logic [3:0] REG_SRC_LO = 4'd0;
	localparam logic [3:0] REG_SRC_HI = 4'd1;
	localparam logic [3:0] REG_DST_X  = 4'd2;
	localparam logic [3:0] REG_DST_Y  = 4'd3;
	localparam logic [3:0] REG_SIZE_X = 4'd4;
	localparam logic [3:0] REG_SIZE_Y = 4'd5;
	localparam logic [3:0] REG_DIR    = 4'd6;
	localparam logic [3:0] REG_TABLE  = 4'd8;
	localparam logic [3:0] REG_SCROLL = 4'd9;
	localparam logic [3:0] REG_LAYER  = 4'd10;
	localparam logic [3:0] REG_BANK   = 4'd11;

	localparam logic [7:0] COLOR_CLEAR = 8'hff;

	typedef struct packed {
		logic [1:0] cmd;
		logic [3:0] reg_addr;
		logic [7:0] data;
	} nbcw_in_t;

	typedef struct packed {
		logic        write_valid;
		logic        layer;
		logic [16:0] vram_address;
		logic [7:0]  pixel_color;
		logic [20:0] rom_address;
		logic        last;
		logic        blit_done;
		logic        status;
	} nbcw_out_t;

	// mask bits: 0 layer0/col1, 1 layer0/col2, 2 layer1/col1, 3 layer1/col2
	typedef struct packed {
		logic [3:0]  mask;
		logic [7:0]  dy1;
		logic [7:0]  dy2;
		logic [8:0]  dx1;
		logic [7:0]  c1;
		logic [7:0]  c2;
		logic [20:0] rom;
		logic        done;
		logic        status;
	} nbcw_entry_t;

endpackage

`default_nettype wire

// ===== hw/rtl/nbcw_stream_if.sv =====
// Valid/ready stream interface with a typed payload.
// Generic; payload type comes from nbcw_pkg at the instance.
`timescale 1ns / 1ps
`default_nettype none

interface nbcw_stream_if #(
	parameter type T = logic
) ();
	logic valid;
	logic ready;
	T     payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/nbcw_front.sv =====
// Front end: register file, blit sequencer, colour table and entry build.
// Depends on nbcw_pkg and nbcw_stream_if.
`timescale 1ns / 1ps
`default_nettype none

module nbcw_front
	import nbcw_pkg::*;
#(
	parameter int ROM_BYTES = NBCW_ROM_BYTES
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         mode,
	nbcw_stream_if.sink       cmd_ch,
	output      logic         push_valid,
	input  wire logic         push_ready,
	output      nbcw_entry_t  push_data
);

	localparam logic [20:0] ROM_MAX    = 21'(ROM_BYTES - 1);
	localparam int          BANK_LIMIT = (ROM_BYTES + NBCW_BANK_BYTES - 1) / NBCW_BANK_BYTES;
	localparam int          BANK_MASK  = ROM_BYTES / NBCW_BANK_BYTES - 1;

	logic [7:0] clut [2048];

	logic [15:0] source_q;
	logic [7:0]  dest_x_q, dest_y_q, size_x_q;
	logic [1:0]  dir_q;
	logic        flip_q;
	logic [6:0]  table_q;
	logic [7:0]  scroll_q;
	logic [3:0]  lsel_q;
	logic [3:0]  bank_q;
	logic [8:0]  cursor_x_q, cursor_y_q, row_start_x_q;
	logic [7:0]  count_x_q, count_y_q, row_len_q;
	logic [20:0] fetch_q;
	logic        active_q;
	logic [1:0]  blit_dir_q;

	logic        valid_s1, l0_s1, l1_s1, trans_s1, done_s1, status_s1;
	logic [7:0]  dy1_s1, dy2_s1, c1_s1, c2_s1;
	logic [8:0]  dx1_s1;
	logic [20:0] rom_s1;

	nbcw_in_t    pay;
	logic        accept, acc_gfx;
	logic [20:0] wrap_addr;
	logic [7:0]  row_base, row_scr, dy1, dy2;
	logic [8:0]  dx1;
	logic [3:0]  nib1, nib2;
	logic        done;

	assign pay          = cmd_ch.payload;
	assign cmd_ch.ready = !valid_s1 || push_ready;
	assign accept       = cmd_ch.valid && cmd_ch.ready;
	assign acc_gfx      = accept && (nbcw_cmd_t'(pay.cmd) == CMD_GFX);

	always_comb begin
		wrap_addr = (fetch_q > ROM_MAX) ? (fetch_q & ROM_MAX) : fetch_q;
		row_base  = cursor_y_q[7:0];
		row_scr   = cursor_y_q[7:0] + scroll_q;
		dy1       = mode ? row_base : row_scr;
		dy2       = mode ? row_scr : 8'h00;
		dx1       = {cursor_x_q[7:0], 1'b0};
		if (!flip_q) begin
			dy1 = dy1 ^ 8'hff;
			dy2 = dy2 ^ 8'hff;
			dx1 = dx1 ^ 9'h1ff;
		end
		nib1 = blit_dir_q[0] ? pay.data[3:0] : pay.data[7:4];
		nib2 = blit_dir_q[0] ? pay.data[7:4] : pay.data[3:0];
		done = active_q && (count_x_q == 8'h00) && (count_y_q == 8'h00);
	end

	// colour table: one write port, two registered read ports
	always_ff @(posedge clk) begin
		if (accept && (nbcw_cmd_t'(pay.cmd) == CMD_CLUT))
			clut[{table_q, pay.reg_addr}] <= pay.data;
		if (acc_gfx) begin
			c1_s1 <= clut[{table_q, nib1}];
			c2_s1 <= clut[{table_q, nib2}];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			source_q      <= '0;
			dest_x_q      <= '0;
			dest_y_q      <= '0;
			size_x_q      <= '0;
			dir_q         <= '0;
			flip_q        <= 1'b0;
			table_q       <= '0;
			scroll_q      <= '0;
			lsel_q        <= '0;
			bank_q        <= '0;
			cursor_x_q    <= '0;
			cursor_y_q    <= '0;
			row_start_x_q <= '0;
			count_x_q     <= '0;
			count_y_q     <= '0;
			row_len_q     <= '0;
			fetch_q       <= '0;
			active_q      <= 1'b0;
			blit_dir_q    <= '0;
			valid_s1      <= 1'b0;
			l0_s1         <= 1'b0;
			l1_s1         <= 1'b0;
			trans_s1      <= 1'b0;
			done_s1       <= 1'b0;
			status_s1     <= 1'b0;
			dy1_s1        <= '0;
			dy2_s1        <= '0;
			dx1_s1        <= '0;
			rom_s1        <= '0;
		end else begin
			if (acc_gfx)
				valid_s1 <= 1'b1;
			else if (push_ready)
				valid_s1 <= 1'b0;

			if (accept && (nbcw_cmd_t'(pay.cmd) == CMD_REG)) begin
				unique case (pay.reg_addr)
					REG_SRC_LO: source_q[7:0]  <= pay.data;
					REG_SRC_HI: source_q[15:8] <= pay.data;
					REG_DST_X:  dest_x_q       <= pay.data;
					REG_DST_Y:  dest_y_q       <= pay.data;
					REG_SIZE_X: size_x_q       <= pay.data;
					REG_SIZE_Y: begin
						// start (or restart) a blit
						blit_dir_q    <= dir_q;
						row_start_x_q <= {1'b0, dest_x_q} + {1'b0, size_x_q};
						cursor_x_q    <= {1'b0, dest_x_q} + {1'b0, size_x_q};
						cursor_y_q    <= {1'b0, dest_y_q} + {1'b0, pay.data};
						row_len_q     <= dir_q[0] ? ~size_x_q : size_x_q;
						count_x_q     <= dir_q[0] ? ~size_x_q : size_x_q;
						count_y_q     <= dir_q[1] ? ~pay.data : pay.data;
						fetch_q       <= {bank_q, 17'h00000} + {4'h0, source_q, 1'b0};
						active_q      <= 1'b1;
					end
					REG_DIR: begin
						dir_q  <= pay.data[1:0];
						flip_q <= pay.data[2];
					end
					REG_TABLE:  table_q  <= pay.data[6:0];
					REG_SCROLL: scroll_q <= pay.data;
					REG_LAYER:  lsel_q   <= pay.data[3:0];
					REG_BANK: begin
						if ({1'b0, pay.data[3:0]} >= 5'(BANK_LIMIT))
							bank_q <= pay.data[3:0] & 4'(BANK_MASK);
						else
							bank_q <= pay.data[3:0];
					end
					default: ;
				endcase
			end

			if (acc_gfx) begin
				if (active_q) begin
					fetch_q <= wrap_addr + 21'd1;
					if (count_x_q != 8'h00) begin
						count_x_q  <= count_x_q - 8'd1;
						cursor_x_q <= blit_dir_q[0] ? cursor_x_q + 9'd1 : cursor_x_q - 9'd1;
					end else if (count_y_q != 8'h00) begin
						count_y_q  <= count_y_q - 8'd1;
						cursor_y_q <= blit_dir_q[1] ? cursor_y_q + 9'd1 : cursor_y_q - 9'd1;
						cursor_x_q <= row_start_x_q;
						count_x_q  <= row_len_q;
					end else begin
						active_q <= 1'b0;
					end
				end
				l0_s1     <= active_q && (!mode || lsel_q[0]);
				l1_s1     <= active_q && mode && lsel_q[1];
				trans_s1  <= lsel_q[3];
				done_s1   <= done;
				status_s1 <= !active_q;
				rom_s1    <= active_q ? wrap_addr : 21'h0;
				dy1_s1    <= dy1;
				dy2_s1    <= dy2;
				dx1_s1    <= dx1;
			end
		end
	end

	always_comb begin
		push_valid     = valid_s1;
		push_data.mask = {l1_s1 && (!trans_s1 || (c2_s1 != COLOR_CLEAR)),
		                  l1_s1 && (!trans_s1 || (c1_s1 != COLOR_CLEAR)),
		                  l0_s1 && (c2_s1 != COLOR_CLEAR),
		                  l0_s1 && (c1_s1 != COLOR_CLEAR)};
		push_data.dy1    = dy1_s1;
		push_data.dy2    = dy2_s1;
		push_data.dx1    = dx1_s1;
		push_data.c1     = c1_s1;
		push_data.c2     = c2_s1;
		push_data.rom    = rom_s1;
		push_data.done   = done_s1;
		push_data.status = status_s1;
	end

	// the final byte of a blit must leave the sequencer idle
	assert property (@(posedge clk) disable iff (!arst_n)
		(acc_gfx && done) |=> !active_q)
		else $error("blit still active after final byte");

endmodule

`default_nettype wire

// ===== hw/rtl/nbcw_fifo.sv =====
// Short flip-flop queue between the front and back ends.
// Depends on nbcw_pkg for the entry type.
`timescale 1ns / 1ps
`default_nettype none

module nbcw_fifo
	import nbcw_pkg::*;
#(
	parameter int DEPTH = NBCW_QUEUE_DEPTH
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push_valid,
	output      logic        push_ready,
	input  wire nbcw_entry_t push_data,
	output      logic        pop_valid,
	input  wire logic        pop_ready,
	output      nbcw_entry_t pop_data
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	nbcw_entry_t      slots_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push, do_pop;

	assign push_ready = (count_q != CNT_W'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_data   = slots_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push)
			slots_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			if (do_push && !do_pop)
				count_q <= count_q + CNT_W'(1);
			else if (do_pop && !do_push)
				count_q <= count_q - CNT_W'(1);
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("queue over capacity");

	assert property (@(posedge clk) disable iff (!arst_n)
		(do_push && !do_pop) |=> (count_q == $past(count_q) + CNT_W'(1)))
		else $error("queue lost a push");

endmodule

`default_nettype wire

// ===== hw/rtl/nbcw_back.sv =====
// Back end: expands one queue entry into 1-4 results through an output register.
// Depends on nbcw_pkg and nbcw_stream_if.
`timescale 1ns / 1ps
`default_nettype none

module nbcw_back
	import nbcw_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        pop_valid,
	output      logic        pop_ready,
	input  wire nbcw_entry_t pop_data,
	nbcw_stream_if.source    res_ch
);

	nbcw_entry_t cur_q;
	logic        cur_valid_q;
	logic [3:0]  mask_q;
	logic        out_valid_q;
	nbcw_out_t   out_q;

	logic        adv, is_last;
	logic [1:0]  idx;
	logic [3:0]  rest;
	nbcw_out_t   res;

	assign res_ch.valid   = out_valid_q;
	assign res_ch.payload = out_q;

	assign adv       = !out_valid_q || res_ch.ready;
	assign pop_ready = adv && (!cur_valid_q || is_last);

	always_comb begin
		if (mask_q[0])
			idx = 2'd0;
		else if (mask_q[1])
			idx = 2'd1;
		else if (mask_q[2])
			idx = 2'd2;
		else
			idx = 2'd3;
		rest    = mask_q & ~(4'b0001 << idx);
		is_last = (rest == 4'b0000);

		res.write_valid = (mask_q != 4'b0000);
		res.layer       = idx[1];
		res.vram_address = {idx[1] ? cur_q.dy2 : cur_q.dy1,
		                    idx[0] ? {cur_q.dx1[8:1], ~cur_q.dx1[0]} : cur_q.dx1};
		res.pixel_color = idx[0] ? cur_q.c2 : cur_q.c1;
		if (!res.write_valid) begin
			res.layer        = 1'b0;
			res.vram_address = '0;
			res.pixel_color  = '0;
		end
		res.rom_address = cur_q.rom;
		res.last        = is_last;
		res.blit_done   = cur_q.done;
		res.status      = cur_q.status;
	end

	always_ff @(posedge clk) begin
		if (adv && cur_valid_q)
			out_q <= res;
		if (pop_ready && pop_valid)
			cur_q <= pop_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			mask_q      <= '0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= cur_valid_q;
			if (pop_ready && pop_valid) begin
				cur_valid_q <= 1'b1;
				mask_q      <= pop_data.mask;
			end else if (pop_ready) begin
				cur_valid_q <= 1'b0;
			end else begin
				mask_q <= rest;
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.status) |-> (out_q.last && !out_q.write_valid))
		else $error("idle-byte result malformed");

	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_q.write_valid) |-> out_q.last)
		else $error("non-write result not marked last");

endmodule

`default_nettype wire

// ===== hw/rtl/nibble_blitter_clut_writer.sv =====
// Nibble blitter with colour-table writer. Commands come in on cmd_ch, one
// transaction per cycle while cmd_ch.ready is high: register writes and
// colour-table writes give no result; a graphics ROM byte gives 1 to 4 results
// on res_ch (layer writes, or one non-write result), emitted one per cycle from
// the output register while res_ch is ready (4 in two-layer mode with both
// layers opaque). The front end (registers, blit sequencer, 2048x8 colour
// table) runs ahead of the output by up to the queue depth plus one staged
// byte; a byte passes the staging register, the queue, the current-entry
// register and the output register. Colour-table entries must be written
// before a blit reads them. two_layer_mode is written through cfg_we/cfg_wdata;
// the user must write it only while the block is idle; the block does not enforce it.
// Depends on nbcw_pkg, nbcw_stream_if, nbcw_front, nbcw_fifo, nbcw_back.
`timescale 1ns / 1ps
`default_nettype none

module nibble_blitter_clut_writer
	import nbcw_pkg::*;
#(
	parameter int ROM_BYTES   = NBCW_ROM_BYTES,
	parameter int QUEUE_DEPTH = NBCW_QUEUE_DEPTH
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     cfg_we,
	input  wire logic     cfg_wdata,
	nbcw_stream_if.sink   cmd_ch,
	nbcw_stream_if.source res_ch
);

	// configuration: two_layer_mode
	logic mode_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
		end else if (cfg_we) begin
			mode_q <= cfg_wdata;
		end
	end

	// front to queue
	logic        f_valid, f_ready;
	nbcw_entry_t f_data;
	// queue to back
	logic        b_valid, b_ready;
	nbcw_entry_t b_data;

	nbcw_front #(
		.ROM_BYTES (ROM_BYTES)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.mode       (mode_q),
		.cmd_ch     (cmd_ch),
		.push_valid (f_valid),
		.push_ready (f_ready),
		.push_data  (f_data)
	);

	nbcw_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (f_valid),
		.push_ready (f_ready),
		.push_data  (f_data),
		.pop_valid  (b_valid),
		.pop_ready  (b_ready),
		.pop_data   (b_data)
	);

	nbcw_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (b_valid),
		.pop_ready (b_ready),
		.pop_data  (b_data),
		.res_ch    (res_ch)
	);

endmodule

`default_nettype wire

// ===== bench/nibble_blitter_clut_writer_tb.sv =====
// Self-checking bench for nibble_blitter_clut_writer: a transaction driver and a
// result monitor around a transaction-level prediction of blits, colour-table lookups.
// Depends on nbcw_pkg, nbcw_stream_if and the nibble_blitter_clut_writer RTL.
`timescale 1ns / 1ps

module nibble_blitter_clut_writer_tb;
	import nbcw_pkg::*;

	localparam int ROM_SIZE    = NBCW_ROM_BYTES;
	localparam int CYCLE_LIMIT = 400000;
	// front end runs ahead of the output by the queue depth plus a staged byte
	localparam int DRAIN_PAUSE = 16;
	localparam int PHASE_ITEMS = 88;

	// registers the block ignores
	localparam logic [3:0] REG_UNUSED_LO = 4'd7;
	localparam logic [3:0] REG_UNUSED_HI = 4'd12;

	// table selects used by the stimulus; every bit takes both values, bit 7 is
	// dropped by the block, so only five banks ever need filling
	localparam logic [7:0] TABLE_PICKS [7] = '{8'h00, 8'h80, 8'h7f, 8'hff, 8'h55, 8'h2a, 8'h01};

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic cfg_wdata;

	nbcw_stream_if #(.T(nbcw_in_t))  cmd_if ();
	nbcw_stream_if #(.T(nbcw_out_t)) res_if ();

	nibble_blitter_clut_writer #(
		.ROM_BYTES(ROM_SIZE)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.cmd_ch   (cmd_if),
		.res_ch   (res_if)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// ---------------------------------------------------------------------
	// Shared bench state
	// ---------------------------------------------------------------------
	nbcw_in_t  cmd_backlog [$];       // transactions waiting for the driver
	nbcw_out_t pixel_writes_due [$];  // predicted results, oldest first
	int        errors = 0;
	int        cycle_count = 0;
	int        src_idle_pct;
	int        snk_idle_pct;

	// ---------------------------------------------------------------------
	// Predicted block state
	// ---------------------------------------------------------------------
	logic        dual;          // two_layer_mode as last written
	logic [7:0]  clut [2048];
	logic [15:0] src_addr;
	logic [7:0]  dst_x, dst_y, size_x, size_y;
	logic [1:0]  dir_bits;
	logic        flipped;
	logic [7:0]  clut_sel, scroll, layer_sel;
	logic [3:0]  bank;
	// blit sequencer
	logic [8:0]  cur_x, cur_y, row_x0;
	logic [7:0]  left_x, left_y, row_len;
	logic [20:0] fetch;
	logic        running;
	logic [1:0]  run_dir;

	// Generator-side shadow: which table banks hold sixteen written entries, the
	// current bank and direction (so bursts can be sized to end on time).
	logic        bank_ready [128] = '{default: 1'b0};
	logic [6:0]  gen_bank = '0;
	logic [1:0]  gen_dir = '0;
	int          items_made;

	function automatic nbcw_out_t pixel_write(logic lyr, logic [16:0] va, logic [7:0] c,
		logic [20:0] rom, logic done);
		pixel_write = '0;
		pixel_write.write_valid  = 1'b1;
		pixel_write.layer        = lyr;
		pixel_write.vram_address = va;
		pixel_write.pixel_color  = c;
		pixel_write.rom_address  = rom;
		pixel_write.blit_done    = done;
	endfunction

	task automatic write_blit_reg(logic [3:0] ra, logic [7:0] d);
		case (ra)
			REG_SRC_LO: src_addr[7:0] = d;
			REG_SRC_HI: src_addr[15:8] = d;
			REG_DST_X:  dst_x = d;
			REG_DST_Y:  dst_y = d;
			REG_SIZE_X: size_x = d;
			REG_SIZE_Y: begin
				// start (or restart): origin, row length and direction latched here
				size_y  = d;
				run_dir = dir_bits;
				row_x0  = {1'b0, dst_x} + {1'b0, size_x};
				row_len = run_dir[0] ? ~size_x : size_x;
				cur_x   = row_x0;
				cur_y   = {1'b0, dst_y} + {1'b0, size_y};
				left_x  = row_len;
				left_y  = run_dir[1] ? ~size_y : size_y;
				fetch   = {bank, 17'b0} + {4'b0, src_addr, 1'b0};
				running = 1'b1;
			end
			REG_DIR: begin
				dir_bits = d[1:0];
				flipped  = d[2];
			end
			REG_TABLE:  clut_sel = d;
			REG_SCROLL: scroll = d;
			REG_LAYER:  layer_sel = d;
			REG_BANK: begin
				bank = d[3:0];
				// banks past the end of the ROM fold back
				if (int'(bank) * NBCW_BANK_BYTES >= ROM_SIZE)
					bank &= 4'(ROM_SIZE / NBCW_BANK_BYTES - 1);
			end
			default: ;
		endcase
	endtask

	// Works out what one accepted transaction produces and queues it.
	task automatic predict_pixels(nbcw_in_t t);
		nbcw_out_t   burst [$];
		nbcw_out_t   r;
		logic [20:0] a;
		logic [8:0]  col1, col2;
		logic [7:0]  row1, row2, c1, c2;
		logic [3:0]  n1, n2;
		logic        done, on0, on1, clear;
		done = 1'b0;
		case (t.cmd)
			CMD_REG:  write_blit_reg(t.reg_addr, t.data);
			CMD_CLUT: clut[{clut_sel[6:0], t.reg_addr}] = t.data;
			CMD_GFX: begin
				if (!running) begin
					// byte with no blit: status only
					r = '0;
					r.status = 1'b1;
					r.last   = 1'b1;
					burst.push_back(r);
				end else begin
					a = fetch;
					if (a >= 21'(ROM_SIZE))
						a &= 21'(ROM_SIZE - 1);
					fetch = a + 21'd1;

					col1 = {cur_x[7:0], 1'b0};
					col2 = {cur_x[7:0], 1'b1};
					if (dual) begin
						row1 = cur_y[7:0];
						row2 = cur_y[7:0] + scroll;
					end else begin
						row1 = cur_y[7:0] + scroll;
						row2 = '0;
					end
					if (!flipped) begin
						col1 = ~col1;
						col2 = ~col2;
						row1 = ~row1;
						row2 = ~row2;
					end
					// x direction decides which nibble lands in the first column
					if (run_dir[0])
						{n1, n2} = {t.data[3:0], t.data[7:4]};
					else
						{n1, n2} = t.data;
					c1 = clut[{clut_sel[6:0], n1}];
					c2 = clut[{clut_sel[6:0], n2}];

					if (left_x != 0) begin
						left_x--;
						cur_x = run_dir[0] ? cur_x + 9'd1 : cur_x - 9'd1;
					end else if (left_y != 0) begin
						left_y--;
						cur_y  = run_dir[1] ? cur_y + 9'd1 : cur_y - 9'd1;
						cur_x  = row_x0;
						left_x = row_len;
					end else begin
						running = 1'b0;
						done    = 1'b1;
					end

					on0   = !dual || layer_sel[0];
					on1   = dual && layer_sel[1];
					clear = layer_sel[3];
					if (on0 && c1 != COLOR_CLEAR)
						burst.push_back(pixel_write(1'b0, {row1, col1}, c1, a, done));
					if (on0 && c2 != COLOR_CLEAR)
						burst.push_back(pixel_write(1'b0, {row1, col2}, c2, a, done));
					if (on1 && (!clear || c1 != COLOR_CLEAR))
						burst.push_back(pixel_write(1'b1, {row2, col1}, c1, a, done));
					if (on1 && (!clear || c2 != COLOR_CLEAR))
						burst.push_back(pixel_write(1'b1, {row2, col2}, c2, a, done));
					if (burst.size() == 0) begin
						// every nibble skipped: one non-write result
						r = '0;
						r.rom_address = a;
						r.blit_done   = done;
						burst.push_back(r);
					end
				end
				burst[burst.size() - 1].last = 1'b1;
				foreach (burst[i])
					pixel_writes_due.push_back(burst[i]);
			end
			default: ;
		endcase
	endtask

	// ---------------------------------------------------------------------
	// Stimulus building
	// ---------------------------------------------------------------------
	function automatic logic [7:0] pick_color();
		// plenty of the clear colour so transparency gets exercised
		pick_color = ($urandom_range(3) == 0) ? COLOR_CLEAR : 8'($urandom_range(255));
	endfunction

	task automatic push_cmd(nbcw_cmd_t c, logic [3:0] ra, logic [7:0] d);
		cmd_backlog.push_back('{cmd: c, reg_addr: ra, data: d});
		if (!(c == CMD_NOP || (c == CMD_REG && (ra == REG_UNUSED_LO || ra >= REG_UNUSED_HI))))
			items_made++;
	endtask

	// Register write; a table select is followed by a fill of that bank the
	// first time it is used, so no lookup ever hits an unwritten entry.
	task automatic push_reg(logic [3:0] ra, logic [7:0] d);
		push_cmd(CMD_REG, ra, d);
		if (ra == REG_DIR)
			gen_dir = d[1:0];
		if (ra == REG_TABLE) begin
			gen_bank = d[6:0];
			if (!bank_ready[gen_bank]) begin
				for (int i = 0; i < 16; i++)
					push_cmd(CMD_CLUT, 4'(i), pick_color());
				bank_ready[gen_bank] = 1'b1;
			end
		end
	endtask

	task automatic push_gfx(logic [7:0] d);
		push_cmd(CMD_GFX, 4'($urandom_range(15)), d);
	endtask

	// Settings that the block reads live, changed mid-blit or between blits.
	task automatic queue_live_change();
		case ($urandom_range(4))
			0: push_reg(REG_SCROLL, 8'($urandom_range(255)));
			1: push_reg(REG_LAYER, 8'($urandom_range(255)));
			2: push_reg(REG_TABLE, TABLE_PICKS[$urandom_range(6)]);
			3: push_reg(REG_DIR, 8'($urandom_range(255)));
			default: push_cmd(CMD_CLUT, 4'($urandom_range(15)), pick_color());
		endcase
	endtask

	// A well-formed blit: some setup, a start, and about as many bytes as it
	// takes; sometimes one short (next start restarts it) or a few over (idle).
	task automatic queue_blit_burst();
		logic [7:0] rx, ry, sx, sy;
		int         nb;
		if ($urandom_range(1)) push_reg(REG_SRC_LO, 8'($urandom_range(255)));
		if ($urandom_range(1)) push_reg(REG_SRC_HI, 8'($urandom_range(255)));
		if ($urandom_range(1)) push_reg(REG_DST_X, 8'($urandom_range(255)));
		if ($urandom_range(1)) push_reg(REG_DST_Y, 8'($urandom_range(255)));
		if ($urandom_range(1)) push_reg(REG_DIR, 8'($urandom_range(255)));
		if ($urandom_range(2) == 0) push_reg(REG_TABLE, TABLE_PICKS[$urandom_range(6)]);
		if ($urandom_range(1)) push_reg(REG_SCROLL, 8'($urandom_range(255)));
		if ($urandom_range(1)) push_reg(REG_LAYER, 8'($urandom_range(255)));
		if ($urandom_range(2) == 0) push_reg(REG_BANK, 8'($urandom_range(255)));

		rx = 8'($urandom_range(3));
		ry = 8'($urandom_range(2));
		sx = gen_dir[0] ? ~rx : rx;
		sy = gen_dir[1] ? ~ry : ry;
		nb = (int'(rx) + 1) * (int'(ry) + 1);
		if ($urandom_range(9) == 0) begin
			// arbitrary size, usually cut short by the next start
			sx = 8'($urandom_range(255));
			sy = 8'($urandom_range(255));
			nb = $urandom_range(6, 1);
		end
		push_reg(REG_SIZE_X, sx);
		push_reg(REG_SIZE_Y, sy);

		case ($urandom_range(9))
			0, 1: if (nb > 1) nb--;
			2:    nb += $urandom_range(2, 1);
			default: ;
		endcase
		for (int i = 0; i < nb; i++) begin
			if ($urandom_range(9) == 0)
				queue_live_change();
			push_gfx(8'($urandom_range(255)));
		end
	endtask

	task automatic queue_random_step();
		int pick;
		pick = $urandom_range(99);
		if (pick < 70) begin
			queue_blit_burst();
		end else if (pick < 80) begin
			case ($urandom_range(2))
				0: push_cmd(CMD_NOP, 4'($urandom_range(15)), 8'($urandom_range(255)));
				1: push_reg(($urandom_range(4) == 0) ? REG_UNUSED_LO
					: 4'(REG_UNUSED_HI + $urandom_range(3)), 8'($urandom_range(255)));
				default: push_cmd(CMD_CLUT, 4'($urandom_range(15)), pick_color());
			endcase
		end else if (pick < 90) begin
			queue_live_change();
		end else begin
			push_gfx(8'($urandom_range(255)));
		end
	endtask

	// Directed opening: idle byte, ignored commands, extreme registers, bank
	// clamp and ROM wrap, transparency on both layers, the no-write result and
	// a restart in the middle of a blit.
	task automatic queue_directed();
		push_reg(REG_TABLE, 8'h00);
		push_cmd(CMD_CLUT, 4'hf, COLOR_CLEAR);
		push_cmd(CMD_CLUT, 4'h0, 8'h00);
		push_cmd(CMD_CLUT, 4'h5, 8'h5a);
		push_gfx(8'hff);                       // no blit yet
		push_cmd(CMD_NOP, 4'hf, 8'hff);
		push_reg(REG_UNUSED_LO, 8'hff);
		push_reg(4'hf, 8'h00);
		push_reg(REG_DIR, 8'h00);              // x and y down, not flipped
		push_reg(REG_LAYER, 8'h03);            // both layers, clear colour drawn on layer 1
		push_reg(REG_SCROLL, 8'hff);
		push_reg(REG_SRC_LO, 8'hff);
		push_reg(REG_SRC_HI, 8'hff);
		push_reg(REG_BANK, 8'hff);             // folds to the top bank
		push_reg(REG_DST_X, 8'hff);
		push_reg(REG_DST_Y, 8'hff);
		push_reg(REG_SIZE_X, 8'h02);
		push_reg(REG_SIZE_Y, 8'h00);
		push_gfx(8'hf0);
		push_gfx(8'h0f);
		push_gfx(8'h5a);                       // fetch address wraps here
		push_gfx(8'h00);                       // blit already finished
		push_reg(REG_DIR, 8'h07);              // x and y up, flipped
		push_reg(REG_LAYER, 8'h0b);            // clear colour skipped on layer 1
		push_reg(REG_SIZE_X, 8'hff);
		push_reg(REG_SIZE_Y, 8'hfe);
		push_gfx(8'hf0);
		push_reg(REG_LAYER, 8'h00);            // nothing enabled
		push_gfx(8'h0f);
		push_reg(REG_LAYER, 8'h01);
		push_reg(REG_SIZE_X, 8'h00);
		push_reg(REG_SIZE_Y, 8'h00);           // long blit
		push_gfx(8'h33);
		push_reg(REG_SIZE_Y, 8'hff);           // restart
		push_gfx(8'hcc);
	endtask

	// ---------------------------------------------------------------------
	// Driver: feeds cmd_ch from the backlog, predicting on each accepted
	// transaction. valid stays high across back-to-back transactions.
	// ---------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_if.valid   <= 1'b0;
			cmd_if.payload <= '0;
		end else begin
			if (cmd_if.valid && cmd_if.ready)
				predict_pixels(cmd_if.payload);
			if (!cmd_if.valid || cmd_if.ready) begin
				if (cmd_backlog.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
					cmd_if.valid   <= 1'b1;
					cmd_if.payload <= cmd_backlog.pop_front();
				end else begin
					cmd_if.valid <= 1'b0;
				end
			end
		end
	end

	// ---------------------------------------------------------------------
	// Monitor: every accepted result against the oldest prediction
	// ---------------------------------------------------------------------
	task automatic check_field(string name, logic [20:0] want, logic [20:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			errors++;
		end
	endtask

	task automatic compare_result(nbcw_out_t want, nbcw_out_t got);
		check_field("write_valid", want.write_valid, got.write_valid);
		check_field("layer", want.layer, got.layer);
		check_field("vram_address", want.vram_address, got.vram_address);
		check_field("pixel_color", want.pixel_color, got.pixel_color);
		check_field("rom_address", want.rom_address, got.rom_address);
		check_field("last", want.last, got.last);
		check_field("blit_done", want.blit_done, got.blit_done);
		check_field("status", want.status, got.status);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_if.ready <= 1'b0;
		end else begin
			if (res_if.valid && res_if.ready) begin
				if (pixel_writes_due.size() == 0) begin
					$error("result with nothing expected: %p", res_if.payload);
					errors++;
				end else begin
					compare_result(pixel_writes_due.pop_front(), res_if.payload);
				end
			end
			res_if.ready <= ($urandom_range(99) >= snk_idle_pct);
		end
	end

	// ---------------------------------------------------------------------
	// Watchdog
	// ---------------------------------------------------------------------
	always @(posedge clk)
		cycle_count <= cycle_count + 1;

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("simulation failed");
		$finish;
	end

	// ---------------------------------------------------------------------
	// Sequence: reset, then three phases. Each phase writes two_layer_mode
	// while the block is idle, sets the idle mix, queues its stimulus and
	// waits until every transaction and every result has gone through.
	// ---------------------------------------------------------------------
	initial begin
		logic next_mode;
		clk            = 1'b0;
		arst_n         = 1'b0;
		cfg_we         = 1'b0;
		cfg_wdata      = 1'b0;
		cmd_if.valid   = 1'b0;
		cmd_if.payload = '0;
		res_if.ready   = 1'b0;
		src_idle_pct   = 0;
		snk_idle_pct   = 0;

		// predicted reset state
		dual      = 1'b0;
		clut      = '{default: 8'h00};
		src_addr  = '0;
		dst_x     = '0;
		dst_y     = '0;
		size_x    = '0;
		size_y    = '0;
		dir_bits  = '0;
		flipped   = 1'b0;
		clut_sel  = '0;
		scroll    = '0;
		layer_sel = '0;
		bank      = '0;
		cur_x     = '0;
		cur_y     = '0;
		row_x0    = '0;
		left_x    = '0;
		left_y    = '0;
		row_len   = '0;
		fetch     = '0;
		running   = 1'b0;
		run_dir   = '0;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		for (int ph = 0; ph < 3; ph++) begin
			// two-layer, single-layer, two-layer again
			next_mode = (ph != 1);
			@(posedge clk);
			cfg_we    <= 1'b1;
			cfg_wdata <= next_mode;
			@(posedge clk);
			cfg_we <= 1'b0;
			dual    = next_mode;

			@(negedge clk);
			case (ph)
				0: begin
					src_idle_pct = 23;
					snk_idle_pct = 58;
				end
				1: begin
					src_idle_pct = 58;
					snk_idle_pct = 23;
				end
				default: begin
					src_idle_pct = 0;
					snk_idle_pct = 0;
				end
			endcase

			if (ph == 0)
				queue_directed();
			items_made = 0;
			while (items_made < PHASE_ITEMS)
				queue_random_step();

			while (cmd_backlog.size() != 0 || cmd_if.valid || pixel_writes_due.size() != 0)
				@(negedge clk);
			// register writes may still be settling in the front end
			repeat (DRAIN_PAUSE) @(negedge clk);
		end

		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
